>>> design/cab_pkg.sv
// ----------------------------------------------------------------------------
// cab_pkg
// Shared widths, codes and pipeline record types of the alpha blit compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package cab_pkg;

    localparam int COORD_W    = 16;
    localparam int ARGB_W     = 32;
    localparam int ADDR_W     = 25;
    localparam int EDGE_W     = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CHAN_N     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_SPAN_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_SPAN_Y = 3'd3;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [15:0] RECIP_255    = 16'h8081;
    localparam int          RECIP_SHIFT  = 23;

    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = 8 / DIV_BITS_PER_STAGE;

    typedef struct packed {
        logic              we;
        logic              opaque;
        logic [ADDR_W-1:0] addr;
        logic [ARGB_W-1:0] src;
    } t_meta;

    typedef struct packed {
        logic [CHAN_N-1:0][7:0] rem;
        logic [CHAN_N-1:0][7:0] low;
        logic [CHAN_N-1:0][7:0] quo;
        logic [CHAN_N-1:0]      sat;
        logic [7:0]             oa;
        logic                   zero;
        t_meta                  meta;
    } t_div;

endpackage

`default_nettype wire

>>> design/cab_in_if.sv
// ----------------------------------------------------------------------------
// cab_in_if
// Pixel request channel: coordinate, source pixel and current destination.
// ----------------------------------------------------------------------------
`default_nettype none

interface cab_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [cab_pkg::COORD_W-1:0]  pixel_x;
    logic signed [cab_pkg::COORD_W-1:0]  pixel_y;
    logic        [cab_pkg::ARGB_W-1:0]   source_argb;
    logic        [cab_pkg::ARGB_W-1:0]   dest_argb;

    modport source (output valid, output pixel_x, output pixel_y,
                    output source_argb, output dest_argb, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input source_argb, input dest_argb, output ready);
endinterface

`default_nettype wire

>>> design/cab_out_if.sv
// ----------------------------------------------------------------------------
// cab_out_if
// Pixel write channel: write strobe, surface address and new pixel value.
// ----------------------------------------------------------------------------
`default_nettype none

interface cab_out_if;
    logic                          valid;
    logic                          ready;
    logic                          write_enable;
    logic [cab_pkg::ADDR_W-1:0]    write_address;
    logic [cab_pkg::ARGB_W-1:0]    blended_argb;

    modport source (output valid, output write_enable, output write_address,
                    output blended_argb, input ready);
    modport sink   (input valid, input write_enable, input write_address,
                    input blended_argb, output ready);
endinterface

`default_nettype wire

>>> design/clipped_alpha_blit_pixel.sv
// ----------------------------------------------------------------------------
// clipped_alpha_blit_pixel
// Clips one ARGB8888 pixel against a rectangle and blends it over the surface.
//
// Each beat on i_pix carries a destination coordinate, the source pixel and
// the pixel currently stored at that place. Each beat on o_res carries the
// write strobe, the linear address y * clip_span_x + x and the new pixel;
// when the strobe is low, the address and the pixel are zero.
// The clip registers are written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the user must write them while no beat is in flight, as the block does not
// enforce it. A span above MAX_SURFACE_DIM is clamped. One beat is taken and
// delivered every cycle while o_res.ready stays high. The path is a chain of
// multiply and correct stages for the two divisions by 255, then a divider
// for the division by the result alpha that retires two quotient bits per
// stage in each of the three color lanes.
// Reset clears all valid bits and loads the clip to the full surface.
// When the receiver holds ready low with a beat waiting, the whole pipeline
// holds and i_pix.ready goes low in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_alpha_blit_pixel #(
    parameter int MAX_SURFACE_DIM = 4096
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    cab_in_if.sink                              i_pix,
    cab_out_if.source                           o_res,
    input  wire                                 i_cfg_we,
    input  wire  [cab_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [cab_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int SPAN_W = $clog2(MAX_SURFACE_DIM + 1);
    localparam int PROD_W = cab_pkg::COORD_W + SPAN_W;
    localparam int SUM_W  = (PROD_W >= cab_pkg::ADDR_W) ? PROD_W + 1 : cab_pkg::ADDR_W + 1;
    localparam int CN     = cab_pkg::CHAN_N;
    localparam int DS     = cab_pkg::DIV_STAGES;

    logic [cab_pkg::EDGE_W-1:0] r_clip_left;
    logic [cab_pkg::EDGE_W-1:0] r_clip_top;
    logic [SPAN_W-1:0]          r_span_x;
    logic [SPAN_W-1:0]          r_span_y;
    logic [SPAN_W-1:0]          n_span;

    logic en;

    logic                       r_s1_valid;
    logic                       r_s1_we;
    logic                       r_s1_opaque;
    logic [cab_pkg::ARGB_W-1:0] r_s1_src;
    logic [cab_pkg::COORD_W-1:0] r_s1_x;
    logic [PROD_W-1:0]          r_s1_aprod;
    logic [7:0]                 r_s1_sa;
    logic [15:0]                r_s1_poa;
    logic [CN-1:0][15:0]        r_s1_pdd;
    logic [CN-1:0][15:0]        r_s1_pss;

    logic                       n_s1_we;
    logic [PROD_W-1:0]          n_s1_aprod;
    logic [15:0]                n_s1_poa;
    logic [CN-1:0][15:0]        n_s1_pdd;
    logic [CN-1:0][15:0]        n_s1_pss;

    logic                       r_s2_valid;
    cab_pkg::t_meta             r_s2_meta;
    logic [7:0]                 r_s2_sa;
    logic [15:0]                r_s2_poa;
    logic [8:0]                 r_s2_oaest;
    logic [CN-1:0][23:0]        r_s2_n3;
    logic [CN-1:0][15:0]        r_s2_pss;

    cab_pkg::t_meta             n_s2_meta;
    logic [8:0]                 n_s2_oaest;
    logic [CN-1:0][23:0]        n_s2_n3;

    logic                       r_s3_valid;
    cab_pkg::t_meta             r_s3_meta;
    logic [7:0]                 r_s3_sa;
    logic [7:0]                 r_s3_oaq;
    logic [CN-1:0][16:0]        r_s3_qest;
    logic [CN-1:0][23:0]        r_s3_n3;
    logic [CN-1:0][15:0]        r_s3_pss;

    logic [7:0]                 n_s3_oaq;
    logic [CN-1:0][16:0]        n_s3_qest;

    logic                       r_s4_valid;
    cab_pkg::t_meta             r_s4_meta;
    logic [7:0]                 r_s4_oa;
    logic [CN-1:0][15:0]        r_s4_q;
    logic [CN-1:0][15:0]        r_s4_pss;

    logic [7:0]                 n_s4_oa;
    logic [CN-1:0][15:0]        n_s4_q;

    logic                       r_dv_valid [DS+1];
    cab_pkg::t_div              r_dv       [DS+1];
    cab_pkg::t_div              n_dv0;

    logic                       r_o_valid;
    logic                       r_o_we;
    logic [cab_pkg::ADDR_W-1:0] r_o_addr;
    logic [cab_pkg::ARGB_W-1:0] r_o_argb;
    logic                       n_o_we;
    logic [cab_pkg::ADDR_W-1:0] n_o_addr;
    logic [cab_pkg::ARGB_W-1:0] n_o_argb;

    function automatic cab_pkg::t_div div_step(input cab_pkg::t_div d_in);
        cab_pkg::t_div d;
        logic [8:0]    t;
        logic          b;
        d = d_in;
        for (int c = 0; c < CN; c++) begin
            for (int k = 0; k < cab_pkg::DIV_BITS_PER_STAGE; k++) begin
                t = {d.rem[c], d.low[c][7]};
                b = (t >= {1'b0, d.oa});
                if (b) begin
                    t = t - {1'b0, d.oa};
                end
                d.rem[c] = t[7:0];
                d.low[c] = {d.low[c][6:0], 1'b0};
                d.quo[c] = {d.quo[c][6:0], b};
            end
        end
        return d;
    endfunction

    assign en          = !r_o_valid || o_res.ready;
    assign i_pix.ready = en;

    // Configuration registers.
    always_comb begin
        if (32'(i_cfg_data) > MAX_SURFACE_DIM) begin
            n_span = SPAN_W'(MAX_SURFACE_DIM);
        end else begin
            n_span = SPAN_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left <= '0;
            r_clip_top  <= '0;
            r_span_x    <= SPAN_W'(MAX_SURFACE_DIM);
            r_span_y    <= SPAN_W'(MAX_SURFACE_DIM);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cab_pkg::CFG_CLIP_LEFT: begin
                    r_clip_left <= i_cfg_data[cab_pkg::EDGE_W-1:0];
                end
                cab_pkg::CFG_CLIP_TOP: begin
                    r_clip_top <= i_cfg_data[cab_pkg::EDGE_W-1:0];
                end
                cab_pkg::CFG_CLIP_SPAN_X: begin
                    r_span_x <= n_span;
                end
                cab_pkg::CFG_CLIP_SPAN_Y: begin
                    r_span_y <= n_span;
                end
                default: begin
                end
            endcase
        end
    end

    // Stage 1: clip test and the first partial products.
    always_comb begin
        logic signed [17:0] xs;
        logic signed [17:0] ys;
        logic signed [17:0] lo_x;
        logic signed [17:0] lo_y;
        logic signed [17:0] hi_x;
        logic signed [17:0] hi_y;
        logic [7:0]         sa;
        logic [7:0]         da;
        logic [PROD_W-1:0]  ya;
        logic [PROD_W-1:0]  sb;
        xs   = 18'(i_pix.pixel_x);
        ys   = 18'(i_pix.pixel_y);
        lo_x = signed'(18'(r_clip_left));
        lo_y = signed'(18'(r_clip_top));
        hi_x = lo_x + signed'(18'(r_span_x));
        hi_y = lo_y + signed'(18'(r_span_y));
        sa   = i_pix.source_argb[31:24];
        da   = i_pix.dest_argb[31:24];
        n_s1_we = (xs >= lo_x) && (xs < hi_x) && (ys >= lo_y) && (ys < hi_y)
                  && (sa != 8'h00);
        ya = PROD_W'(unsigned'(i_pix.pixel_y));
        sb = PROD_W'(r_span_x);
        n_s1_aprod = ya * sb;
        n_s1_poa = {8'h00, da} * {8'h00, 8'hFF - sa};
        for (int c = 0; c < CN; c++) begin
            n_s1_pdd[c] = {8'h00, i_pix.dest_argb[8*c +: 8]} * {8'h00, da};
            n_s1_pss[c] = {8'h00, i_pix.source_argb[8*c +: 8]} * {8'h00, sa};
        end
    end

    // Stage 2: address sum, reciprocal estimate of the alpha term, third factor.
    always_comb begin
        logic [SUM_W-1:0] sum;
        logic [31:0]      p;
        sum = SUM_W'(r_s1_aprod) + SUM_W'(r_s1_x);
        n_s2_meta.we     = r_s1_we;
        n_s2_meta.opaque = r_s1_opaque;
        n_s2_meta.addr   = sum[cab_pkg::ADDR_W-1:0];
        n_s2_meta.src    = r_s1_src;
        p = {16'h0000, r_s1_poa} * {16'h0000, cab_pkg::RECIP_255};
        n_s2_oaest = p[cab_pkg::RECIP_SHIFT +: 9];
        for (int c = 0; c < CN; c++) begin
            n_s2_n3[c] = {8'h00, r_s1_pdd[c]} * {16'h0000, 8'hFF - r_s1_sa};
        end
    end

    // Stage 3: correct the alpha quotient, estimate the color quotients.
    always_comb begin
        logic [16:0] e255;
        logic [39:0] p;
        e255 = {r_s2_oaest, 8'h00} - {8'h00, r_s2_oaest};
        if ({1'b0, r_s2_poa} < e255) begin
            n_s3_oaq = 8'(r_s2_oaest - 9'd1);
        end else begin
            n_s3_oaq = r_s2_oaest[7:0];
        end
        for (int c = 0; c < CN; c++) begin
            p = {16'h0000, r_s2_n3[c]} * {24'h000000, cab_pkg::RECIP_255};
            n_s3_qest[c] = p[cab_pkg::RECIP_SHIFT +: 17];
        end
    end

    // Stage 4: correct the color quotients and form the result alpha.
    always_comb begin
        logic [24:0] q255;
        n_s4_oa = r_s3_sa + r_s3_oaq;
        for (int c = 0; c < CN; c++) begin
            q255 = {r_s3_qest[c], 8'h00} - {8'h00, r_s3_qest[c]};
            if ({1'b0, r_s3_n3[c]} < q255) begin
                n_s4_q[c] = 16'(r_s3_qest[c] - 17'd1);
            end else begin
                n_s4_q[c] = r_s3_qest[c][15:0];
            end
        end
    end

    // Stage 5: numerators, overflow check and divider setup.
    always_comb begin
        logic [16:0] num;
        n_dv0.oa   = r_s4_oa;
        n_dv0.zero = (r_s4_oa == 8'h00);
        n_dv0.meta = r_s4_meta;
        for (int c = 0; c < CN; c++) begin
            num = {1'b0, r_s4_pss[c]} + {1'b0, r_s4_q[c]};
            n_dv0.sat[c] = (num[16:8] >= {1'b0, r_s4_oa});
            n_dv0.rem[c] = num[15:8];
            n_dv0.low[c] = num[7:0];
            n_dv0.quo[c] = 8'h00;
        end
    end

    // Output formatting.
    always_comb begin
        cab_pkg::t_div d;
        d        = r_dv[DS];
        n_o_we   = d.meta.we;
        n_o_addr = '0;
        n_o_argb = '0;
        if (d.meta.we) begin
            n_o_addr = d.meta.addr;
            if (d.meta.opaque) begin
                n_o_argb = d.meta.src;
            end else if (!d.zero) begin
                n_o_argb[31:24] = d.oa;
                for (int c = 0; c < CN; c++) begin
                    n_o_argb[8*c +: 8] = d.sat[c] ? 8'hFF : d.quo[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            for (int s = 0; s <= DS; s++) begin
                r_dv_valid[s] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid    <= i_pix.valid;
            r_s2_valid    <= r_s1_valid;
            r_s3_valid    <= r_s2_valid;
            r_s4_valid    <= r_s3_valid;
            r_dv_valid[0] <= r_s4_valid;
            for (int s = 1; s <= DS; s++) begin
                r_dv_valid[s] <= r_dv_valid[s-1];
            end
            r_o_valid <= r_dv_valid[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_we     <= n_s1_we;
            r_s1_opaque <= (i_pix.source_argb[31:24] == cab_pkg::ALPHA_OPAQUE);
            r_s1_src    <= i_pix.source_argb;
            r_s1_x      <= unsigned'(i_pix.pixel_x);
            r_s1_aprod  <= n_s1_aprod;
            r_s1_sa     <= i_pix.source_argb[31:24];
            r_s1_poa    <= n_s1_poa;
            r_s1_pdd    <= n_s1_pdd;
            r_s1_pss    <= n_s1_pss;

            r_s2_meta   <= n_s2_meta;
            r_s2_sa     <= r_s1_sa;
            r_s2_poa    <= r_s1_poa;
            r_s2_oaest  <= n_s2_oaest;
            r_s2_n3     <= n_s2_n3;
            r_s2_pss    <= r_s1_pss;

            r_s3_meta   <= r_s2_meta;
            r_s3_sa     <= r_s2_sa;
            r_s3_oaq    <= n_s3_oaq;
            r_s3_qest   <= n_s3_qest;
            r_s3_n3     <= r_s2_n3;
            r_s3_pss    <= r_s2_pss;

            r_s4_meta   <= r_s3_meta;
            r_s4_oa     <= n_s4_oa;
            r_s4_q      <= n_s4_q;
            r_s4_pss    <= r_s3_pss;

            r_dv[0]     <= n_dv0;
            for (int s = 1; s <= DS; s++) begin
                r_dv[s] <= div_step(r_dv[s-1]);
            end

            r_o_we      <= n_o_we;
            r_o_addr    <= n_o_addr;
            r_o_argb    <= n_o_argb;
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.write_enable  = r_o_we;
    assign o_res.write_address = r_o_addr;
    assign o_res.blended_argb  = r_o_argb;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_s1_valid)
        else $error("Accepted beat did not enter the first stage.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> $stable(r_s4_valid) && $stable(r_s1_valid))
        else $error("Pipeline advanced while the output was stalled.");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.write_enable |->
            o_res.write_address == '0 && o_res.blended_argb == '0)
        else $error("Suppressed write carries a nonzero address or pixel.");

    a_write_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.write_enable |-> o_res.blended_argb[31:24] != 8'h00)
        else $error("Written pixel has zero alpha.");

    a_blend_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid && r_s4_meta.we && !r_s4_meta.opaque |-> r_s4_oa != 8'h00)
        else $error("Blend result alpha is zero for a nonzero source alpha.");

endmodule

`default_nettype wire

>>> tb/clipped_alpha_blit_pixel_test.sv
// ----------------------------------------------------------------------------
// clipped_alpha_blit_pixel_test
// Self-checking testbench of the clipped alpha blit compositor.
//
// Pixel beats are driven on the request channel and each one is predicted:
// the clip test against the rectangle held in the registers, the linear
// address and the straight-alpha over blend with saturated channels. Every
// output beat is compared with the oldest prediction. A directed part covers
// the window edges, register extremes and blend corner cases; random phases
// reprogram the clip and stream pixels, gapped on both sides in all but one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module clipped_alpha_blit_pixel_test;

    localparam int SURFACE_DIM = 4096;
    localparam int HALF_PERIOD = 5;
    localparam int PIPE_DEPTH  = 10;
    localparam int IDLE_PCT    = 23;
    localparam int RANDOM_PHASES    = 5;
    localparam int PIXELS_PER_PHASE = 226;

    localparam logic [cab_pkg::CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd4;
    localparam logic [cab_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic                       we;
        logic [cab_pkg::ADDR_W-1:0] addr;
        logic [cab_pkg::ARGB_W-1:0] argb;
    } t_pixel_write;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [cab_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [cab_pkg::CFG_DATA_W-1:0] i_cfg_data;

    cab_in_if  pix_bus ();
    cab_out_if res_bus ();

    clipped_alpha_blit_pixel #(
        .MAX_SURFACE_DIM(SURFACE_DIM)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix_bus),
        .o_res     (res_bus),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    logic [cab_pkg::EDGE_W-1:0]     clip_left;
    logic [cab_pkg::EDGE_W-1:0]     clip_top;
    logic [cab_pkg::CFG_DATA_W-1:0] span_x;
    logic [cab_pkg::CFG_DATA_W-1:0] span_y;

    t_pixel_write pending_writes[$];
    int unsigned  mismatch_count;
    bit           steady;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = cab_pkg::CFG_CLIP_LEFT;
        i_cfg_data = '0;
        pix_bus.valid = 1'b0;
        pix_bus.pixel_x = '0;
        pix_bus.pixel_y = '0;
        pix_bus.source_argb = '0;
        pix_bus.dest_argb = '0;
        res_bus.ready = 1'b0;
        mismatch_count = 0;
        steady = 1'b0;
        clip_left = '0;
        clip_top = '0;
        span_x = cab_pkg::CFG_DATA_W'(SURFACE_DIM);
        span_y = cab_pkg::CFG_DATA_W'(SURFACE_DIM);
    end

    always #(HALF_PERIOD) i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    always @(negedge i_clk) begin
        res_bus.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic [cab_pkg::ARGB_W-1:0] over_blend(
            input logic [cab_pkg::ARGB_W-1:0] src,
            input logic [cab_pkg::ARGB_W-1:0] dst);
        int unsigned sa;
        int unsigned da;
        int unsigned oa;
        int unsigned sc;
        int unsigned dc;
        int unsigned v;
        logic [cab_pkg::ARGB_W-1:0] pix;
        sa = src[31:24];
        da = dst[31:24];
        if (sa == 255) begin
            return src;
        end
        oa = sa + da * (255 - sa) / 255;
        if (oa == 0) begin
            return '0;
        end
        pix = '0;
        pix[31:24] = oa[7:0];
        for (int c = 0; c < cab_pkg::CHAN_N; c++) begin
            sc = src[8*c +: 8];
            dc = dst[8*c +: 8];
            v = (sc * sa + dc * da * (255 - sa) / 255) / oa;
            pix[8*c +: 8] = (v > 255) ? 8'hFF : v[7:0];
        end
        return pix;
    endfunction

    function automatic t_pixel_write predict_write(
            input logic signed [cab_pkg::COORD_W-1:0] x,
            input logic signed [cab_pkg::COORD_W-1:0] y,
            input logic [cab_pkg::ARGB_W-1:0] src,
            input logic [cab_pkg::ARGB_W-1:0] dst);
        t_pixel_write w;
        int  xi;
        int  yi;
        bit  in_clip;
        logic [63:0] lin;
        xi = int'(x);
        yi = int'(y);
        in_clip = xi >= int'(clip_left) && xi < int'(clip_left) + int'(span_x) &&
                  yi >= int'(clip_top) && yi < int'(clip_top) + int'(span_y);
        w.we = in_clip && (src[31:24] != 8'h00);
        w.addr = '0;
        w.argb = '0;
        if (w.we) begin
            lin = 64'(yi) * 64'(span_x) + 64'(xi);
            w.addr = lin[cab_pkg::ADDR_W-1:0];
            w.argb = over_blend(src, dst);
        end
        return w;
    endfunction

    function automatic void apply_clip_write(input logic [cab_pkg::CFG_IDX_W-1:0] idx,
                                             input logic [cab_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            cab_pkg::CFG_CLIP_LEFT: begin
                clip_left = data[cab_pkg::EDGE_W-1:0];
            end
            cab_pkg::CFG_CLIP_TOP: begin
                clip_top = data[cab_pkg::EDGE_W-1:0];
            end
            cab_pkg::CFG_CLIP_SPAN_X: begin
                span_x = (int'(data) > SURFACE_DIM) ?
                         cab_pkg::CFG_DATA_W'(SURFACE_DIM) : data;
            end
            cab_pkg::CFG_CLIP_SPAN_Y: begin
                span_y = (int'(data) > SURFACE_DIM) ?
                         cab_pkg::CFG_DATA_W'(SURFACE_DIM) : data;
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : check_results
        t_pixel_write want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected beat, actual we=%0b addr=%h argb=%h", $time,
                         res_bus.write_enable, res_bus.write_address,
                         res_bus.blended_argb);
                mismatch_count++;
            end else begin
                want = pending_writes.pop_front();
                if (res_bus.write_enable !== want.we) begin
                    $display("%0t: write_enable expected %0b actual %0b", $time,
                             want.we, res_bus.write_enable);
                    mismatch_count++;
                end
                if (res_bus.write_address !== want.addr) begin
                    $display("%0t: write_address expected %h actual %h", $time,
                             want.addr, res_bus.write_address);
                    mismatch_count++;
                end
                if (res_bus.blended_argb !== want.argb) begin
                    $display("%0t: blended_argb expected %h actual %h", $time,
                             want.argb, res_bus.blended_argb);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_pixel(input logic signed [cab_pkg::COORD_W-1:0] x,
                              input logic signed [cab_pkg::COORD_W-1:0] y,
                              input logic [cab_pkg::ARGB_W-1:0] src,
                              input logic [cab_pkg::ARGB_W-1:0] dst);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            pix_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_bus.valid = 1'b1;
        pix_bus.pixel_x = x;
        pix_bus.pixel_y = y;
        pix_bus.source_argb = src;
        pix_bus.dest_argb = dst;
        do begin
            @(posedge i_clk);
        end while (!pix_bus.ready);
        pending_writes.push_back(predict_write(x, y, src, dst));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        pix_bus.valid = 1'b0;
        while (pending_writes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_clip_reg(input logic [cab_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [cab_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        apply_clip_write(idx, data);
    endtask

    function automatic logic signed [cab_pkg::COORD_W-1:0] pick_coord(input int origin,
                                                                      input int span);
        int v;
        if ($urandom_range(0, 99) < 75) begin
            v = origin + int'($urandom_range(0, span + 7)) - 4;
        end else begin
            v = int'($urandom_range(0, 65535));
        end
        return v[cab_pkg::COORD_W-1:0];
    endfunction

    function automatic logic [cab_pkg::ARGB_W-1:0] pick_argb();
        int unsigned r;
        logic [cab_pkg::ARGB_W-1:0] pix;
        r = $urandom_range(0, 99);
        pix = $urandom;
        if (r < 10) begin
            pix[31:24] = 8'h00;
        end else if (r < 20) begin
            pix[31:24] = cab_pkg::ALPHA_OPAQUE;
        end
        return pix;
    endfunction

    task automatic test_full_surface();
        send_pixel(16'sd0, 16'sd0, 32'h80FF8000, 32'hFF102030);
        send_pixel(16'sd4095, 16'sd4095, 32'hFF123456, 32'h00ABCDEF);
        send_pixel(16'sd4096, 16'sd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixel(16'sd0, 16'sd4096, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixel(-16'sd1, 16'sd5, 32'hFFFFFFFF, 32'h00000000);
        send_pixel(16'sd5, -16'sd1, 32'hFFFFFFFF, 32'h00000000);
        send_pixel(16'h8000, 16'h8000, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixel(16'h7FFF, 16'h7FFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixel(16'sd100, 16'sd200, 32'h00FFFFFF, 32'hFFFFFFFF);
        send_pixel(16'sd7, 16'sd9, 32'h7F00FF80, 32'h00FFFFFF);
        send_pixel(16'sd7, 16'sd9, 32'h01FFFFFF, 32'h64FFFFFF);
        send_pixel(16'sd1, 16'sd1, 32'hFE000000, 32'hFFFFFFFF);
        send_pixel(16'sd2, 16'sd3, 32'h01000000, 32'h00000000);
        wait_drained();
    endtask

    task automatic test_clip_registers();
        write_clip_reg(cab_pkg::CFG_CLIP_LEFT, 13'd4095);
        write_clip_reg(cab_pkg::CFG_CLIP_TOP, 13'd4095);
        write_clip_reg(cab_pkg::CFG_CLIP_SPAN_X, 13'd4096);
        write_clip_reg(cab_pkg::CFG_CLIP_SPAN_Y, 13'd4096);
        send_pixel(16'sd4095, 16'sd4095, 32'hFFA5A5A5, 32'h00000000);
        send_pixel(16'sd8190, 16'sd8190, 32'hC0123456, 32'hFF654321);
        send_pixel(16'sd8191, 16'sd8190, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixel(16'sd4094, 16'sd4095, 32'hFFFFFFFF, 32'hFFFFFFFF);
        wait_drained();
        write_clip_reg(cab_pkg::CFG_CLIP_SPAN_X, 13'd0);
        send_pixel(16'sd4095, 16'sd4095, 32'hFFFFFFFF, 32'hFFFFFFFF);
        wait_drained();
        write_clip_reg(cab_pkg::CFG_CLIP_SPAN_X, 13'h1FFF);
        write_clip_reg(cab_pkg::CFG_CLIP_LEFT, 13'h1FFF);
        write_clip_reg(cab_pkg::CFG_CLIP_TOP, 13'h1000);
        write_clip_reg(cab_pkg::CFG_CLIP_SPAN_Y, 13'd4097);
        send_pixel(16'sd8190, 16'sd0, 32'h40112233, 32'h80445566);
        send_pixel(16'sd4095, 16'sd4095, 32'hFFFFFFFF, 32'hFFFFFFFF);
        wait_drained();
        write_clip_reg(CFG_UNUSED_FIRST, 13'd0);
        write_clip_reg(CFG_UNUSED_LAST, 13'h1FFF);
        send_pixel(16'sd4095, 16'sd4095, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixel(16'sd8190, 16'sd4095, 32'hFFFFFFFF, 32'hFFFFFFFF);
        wait_drained();
    endtask

    task automatic test_random_blits();
        int unsigned r;
        logic [cab_pkg::CFG_DATA_W-1:0] sx;
        logic [cab_pkg::CFG_DATA_W-1:0] sy;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            steady = (phase == 2);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                sx = 13'd0;
                sy = 13'($urandom_range(1, 64));
            end else if (r < 25) begin
                sx = 13'($urandom_range(SURFACE_DIM + 1, 8191));
                sy = 13'($urandom_range(SURFACE_DIM, 8191));
            end else begin
                sx = 13'($urandom_range(1, 300));
                sy = 13'($urandom_range(1, 300));
            end
            write_clip_reg(cab_pkg::CFG_CLIP_LEFT, 13'($urandom_range(0, 8191)));
            write_clip_reg(cab_pkg::CFG_CLIP_TOP, 13'($urandom_range(0, 8191)));
            write_clip_reg(cab_pkg::CFG_CLIP_SPAN_X, sx);
            write_clip_reg(cab_pkg::CFG_CLIP_SPAN_Y, sy);
            if ($urandom_range(0, 1) == 1) begin
                write_clip_reg(3'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                               13'($urandom_range(0, 8191)));
            end
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                send_pixel(pick_coord(int'(clip_left), int'(span_x)),
                           pick_coord(int'(clip_top), int'(span_y)),
                           pick_argb(), pick_argb());
            end
        end
        steady = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_full_surface();
        test_clip_registers();
        test_random_blits();
        repeat (PIPE_DEPTH + 2) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
